@@ rtl/tma_pkg.sv @@
// Shared types and codes for the trimmed moving average block.
package tma_pkg;

    localparam int SampleW = 16;

    typedef logic signed [SampleW-1:0] sample_t;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_START,
        S_DIV,
        S_DONE
    } state_t;

endpackage

@@ rtl/trimmed_moving_average.sv @@
// Top level of the trimmed moving average: sample ring, scan sequencer and result register.
//
// The block stores the last DEPTH signed samples in a ring and answers each query with the
// rounded mean, or, in trimmed mode once the ring is full, with the rounded mean of the
// middle KEEP values in sorted order. An add beat produces no result. A query on an
// empty ring skips the scan and the divider and goes straight to the result register.
// For a plain mean, one comparator and accumulator visit one stored entry per cycle, then
// a divider produces one quotient bit per cycle. For a trimmed mean, each entry is ranked
// against every other entry through that same comparator, one pair per cycle, read from a
// dual-port RAM. The input is stalled for the whole of a query; a finished result waits in
// an output register, so add beats are taken while it is still held.
module trimmed_moving_average
    import tma_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int KEEP  = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    kind,
    input  sample_t sample,
    output logic    out_valid,
    input  logic    out_stall,
    output sample_t average,
    output logic    empty_res
);

    localparam int AW        = $clog2(DEPTH);
    localparam int DW        = $clog2(DEPTH + 1);
    localparam int SW        = SampleW + AW;
    localparam int NW        = SW + 2;
    localparam int DENW      = DW + 1;
    localparam int KeepEff   = (KEEP > DEPTH) ? DEPTH : KEEP;
    localparam int TrimStart = (DEPTH - KeepEff) / 2;
    localparam int TrimEnd   = TrimStart + KeepEff;

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]        wp_reg;
    logic                 full_reg;
    logic                 trimmed_mode_reg;
    logic                 trim_reg;
    logic                 empty_q_reg;
    logic [DW-1:0]        div_reg;
    logic [AW-1:0]        i_reg;
    logic [AW-1:0]        j_reg;
    logic                 p_valid_reg;
    logic [AW-1:0]        p_i_reg;
    logic [AW-1:0]        p_j_reg;
    logic                 p_last_reg;
    logic [AW-1:0]        rank_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 out_valid_reg;
    sample_t              average_reg;
    logic                 empty_res_reg;

    logic                   in_accept;
    logic                   add_acc;
    logic                   query_acc;
    logic                   is_empty;
    logic                   last_i;
    logic                   last_j;
    logic                   scan_issue;
    logic                   div_start;
    logic                   out_load;
    logic                   stall_c;
    logic [SampleW-1:0]     rd_a;
    logic [SampleW-1:0]     rd_b;
    sample_t                pivot;
    sample_t                other;
    logic                   b_less;
    logic [AW-1:0]          rank_fin;
    logic                   in_window;
    sample_t                addend;
    logic signed [SW-1:0]   addend_ext;
    logic signed [SW-1:0]   sum_next;
    logic signed [NW-1:0]   num_c;
    logic [DENW-1:0]        den_c;
    logic                   div_busy;
    sample_t                div_quot;

    assign in_accept = in_valid && !in_stall;
    assign add_acc   = in_accept && (kind == KIND_ADD);
    assign query_acc = in_accept && (kind == KIND_QUERY);
    assign is_empty  = !full_reg && (wp_reg == '0);
    assign last_j    = j_reg == AW'(DEPTH - 1);
    assign last_i    = !trim_reg || (i_reg == AW'(DEPTH - 1));

    tma_ram #(
        .WIDTH (SampleW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (add_acc),
        .waddr   (wp_reg),
        .wdata   (sample),
        .raddr_a (i_reg),
        .rdata_a (rd_a),
        .raddr_b (j_reg),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = is_empty ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_j && last_i)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stall_c    = 1'b1;
        scan_issue = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                stall_c = 1'b0;
            end
            S_SCAN:
            begin
                scan_issue = 1'b1;
            end
            S_START:
            begin
                div_start = 1'b1;
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                stall_c = 1'b1;
            end
        endcase
    end

    assign in_stall = stall_c;

    // Each stored entry is ranked by counting the entries that sort ahead of it; equal values
    // are ordered by address, so the ranks form the same order as a stable sort.
    assign pivot      = rd_a;
    assign other      = rd_b;
    assign b_less     = (other < pivot) || ((other == pivot) && (p_j_reg < p_i_reg));
    assign rank_fin   = rank_reg + AW'(b_less);
    assign in_window  = ({1'b0, rank_fin} >= (AW + 1)'(TrimStart))
                     && ({1'b0, rank_fin} < (AW + 1)'(TrimEnd));

    always_comb
    begin
        addend = '0;
        if (trim_reg)
        begin
            if (p_last_reg && in_window)
            begin
                addend = pivot;
            end
        end
        else if (full_reg || (p_j_reg < wp_reg))
        begin
            addend = other;
        end
    end

    assign addend_ext = SW'(addend);
    assign sum_next   = sum_reg + addend_ext;

    assign num_c = {sum_reg[SW-1], sum_reg, 1'b0} + NW'(div_reg);
    assign den_c = {div_reg, 1'b0};

    tma_div #(
        .NUM_W (NW),
        .DEN_W (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_c),
        .den   (den_c),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wp_reg           <= '0;
            full_reg         <= 1'b0;
            trimmed_mode_reg <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            p_valid_reg      <= 1'b0;
            rank_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= scan_issue;
            if (cfg_wr_en)
            begin
                trimmed_mode_reg <= cfg_wr_data;
            end
            if (add_acc)
            begin
                if (wp_reg == AW'(DEPTH - 1))
                begin
                    wp_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + AW'(1);
                end
            end
            if (query_acc)
            begin
                i_reg    <= '0;
                j_reg    <= '0;
                rank_reg <= '0;
            end
            else if (scan_issue)
            begin
                if (last_j)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + AW'(1);
                end
                else
                begin
                    j_reg <= j_reg + AW'(1);
                end
            end
            if (p_valid_reg)
            begin
                rank_reg <= p_last_reg ? '0 : rank_fin;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_i_reg    <= i_reg;
        p_j_reg    <= j_reg;
        p_last_reg <= last_j;
        if (query_acc)
        begin
            sum_reg     <= '0;
            trim_reg    <= trimmed_mode_reg && full_reg;
            empty_q_reg <= is_empty;
            if (trimmed_mode_reg && full_reg)
            begin
                div_reg <= DW'(KeepEff);
            end
            else if (full_reg)
            begin
                div_reg <= DW'(DEPTH);
            end
            else
            begin
                div_reg <= DW'(wp_reg);
            end
        end
        else if (p_valid_reg)
        begin
            sum_reg <= sum_next;
        end
        if (out_load)
        begin
            average_reg   <= empty_q_reg ? '0 : div_quot;
            empty_res_reg <= empty_q_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign empty_res = empty_res_reg;

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= AW'(DEPTH - 1))
        else $error("write pointer beyond the ring");

    a_full_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (add_acc && (wp_reg == AW'(DEPTH - 1))) |=> full_reg)
        else $error("ring not marked full after wrapping");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && empty_q_reg) |-> (!full_reg && (wp_reg == '0)))
        else $error("empty result while samples are stored");

endmodule

@@ rtl/tma_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module tma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/tma_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient truncated towards zero.
module tma_div
    import tma_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output sample_t                 quot
);

    localparam int CntW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] mag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quot_full;

    assign num_u  = num;
    assign mag_in = num_u[NUM_W-1] ? (NUM_W'(~num_u) + NUM_W'(1)) : num_u;

    assign trial    = {rem_reg, q_reg[NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag_in;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num_u[NUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quot_full = neg_reg ? (NUM_W'(~q_reg) + NUM_W'(1)) : q_reg;
    assign quot      = quot_full[SampleW-1:0];
    assign busy      = busy_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for trimmed_moving_average: random and directed beats, both modes.
module testbench
    import tma_pkg::*;
();

    localparam int RING_DEPTH   = 16;
    localparam int KEEP_COUNT   = 8;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 320;
    localparam logic MODE_PLAIN   = 1'b0;
    localparam logic MODE_TRIMMED = 1'b1;

    typedef struct {
        logic    kind;
        sample_t sample;
    } beat_t;

    typedef struct {
        sample_t average;
        logic    empty;
    } mean_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_wr_en = 1'b0;
    logic    cfg_wr_data = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    logic    kind = KIND_ADD;
    sample_t sample = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t average;
    logic    empty_res;

    beat_t   beat_fifo[$];
    mean_t   pending_means[$];
    beat_t   next_beat;
    mean_t   expected_mean;
    logic    in_took = 1'b0;
    logic    jitter_on = 1'b1;
    logic    hold_go = 1'b0;
    logic    sink_hold = 1'b0;

    sample_t     ring[RING_DEPTH] = '{default: '0};
    int unsigned wr_ptr = 0;
    logic        ring_wrapped = 1'b0;
    logic        trim_on = MODE_PLAIN;

    int beats_in = 0;
    int means_checked = 0;
    int mismatches = 0;

    trimmed_moving_average #(
        .DEPTH(RING_DEPTH),
        .KEEP (KEEP_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average    (average),
        .empty_res  (empty_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void store_sample(sample_t s);
        ring[wr_ptr] = s;
        if (wr_ptr == RING_DEPTH - 1)
        begin
            wr_ptr = 0;
            ring_wrapped = 1'b1;
        end
        else
        begin
            wr_ptr++;
        end
    endfunction

    function automatic mean_t mean_of_ring();
        sample_t sorted[RING_DEPTH];
        sample_t held;
        longint  total;
        longint  divisor;
        longint  quotient;
        int      keep;
        int      first;
        int      j;
        mean_t   m;
        total = 0;
        m.empty = 1'b0;
        m.average = '0;
        if (!ring_wrapped && wr_ptr == 0)
        begin
            m.empty = 1'b1;
            return m;
        end
        if (trim_on && ring_wrapped)
        begin
            keep = (KEEP_COUNT > RING_DEPTH) ? RING_DEPTH : KEEP_COUNT;
            if (keep < 1)
                keep = 1;
            sorted = ring;
            for (int i = 1; i < RING_DEPTH; i++)
            begin
                held = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > held)
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = held;
            end
            first = (RING_DEPTH - keep) / 2;
            for (int i = first; i < first + keep && i < RING_DEPTH; i++)
                total += sorted[i];
            divisor = keep;
        end
        else
        begin
            foreach (ring[i])
                total += ring[i];
            divisor = ring_wrapped ? RING_DEPTH : longint'(wr_ptr);
        end
        quotient = (2 * total + divisor) / (2 * divisor);
        m.average = quotient[SampleW-1:0];
        return m;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            beats_in++;
            if (kind == KIND_ADD)
                store_sample(sample);
            else
                pending_means.push_back(mean_of_ring());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
            begin
                report_mismatch($sformatf("average %0d arrived with no query outstanding",
                                          average));
            end
            else
            begin
                expected_mean = pending_means.pop_front();
                means_checked++;
                if (average !== expected_mean.average)
                    report_mismatch($sformatf("average %0d, expected %0d",
                                              average, expected_mean.average));
                if (empty_res !== expected_mean.empty)
                    report_mismatch($sformatf("empty_res %b, expected %b",
                                              empty_res, expected_mean.empty));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (beat_fifo.size() != 0 && !(jitter_on && $urandom_range(99) < IDLE_PCT))
            begin
                next_beat = beat_fifo.pop_front();
                in_valid <= 1'b1;
                kind <= next_beat.kind;
                sample <= next_beat.sample;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= sink_hold || (jitter_on && $urandom_range(99) < IDLE_PCT);
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic add_beat(logic k, sample_t s);
        beat_t b;
        b.kind = k;
        b.sample = s;
        beat_fifo.push_back(b);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return sample_t'(int'($urandom_range(8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_random(int count, int query_pct);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < query_pct)
                add_beat(KIND_QUERY, sample_t'($urandom));
            else
                add_beat(KIND_ADD, random_sample());
        end
    endtask

    task automatic drain();
        while (beat_fifo.size() != 0 || in_valid || pending_means.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        trim_on = m;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // A partly filled ring in trimmed mode still gives the plain mean.
        set_mode(MODE_TRIMMED);
        add_beat(KIND_QUERY, 16'sh7FFF);
        add_beat(KIND_ADD, 16'sh7FFF);
        add_beat(KIND_QUERY, 16'sh8000);
        add_beat(KIND_ADD, 16'sh8000);
        add_beat(KIND_QUERY, '0);
        add_beat(KIND_ADD, -16'sd1);
        add_beat(KIND_ADD, -16'sd2);
        add_beat(KIND_QUERY, '1);
        for (int n = 0; n < 11; n++)
            add_beat(KIND_ADD, n[0] ? 16'sh8000 : 16'sh7FFF);
        add_beat(KIND_QUERY, '0);

        set_mode(MODE_PLAIN);
        add_beat(KIND_QUERY, '0);
        add_beat(KIND_ADD, 16'sh7FFF);
        add_beat(KIND_QUERY, '0);

        set_mode(MODE_TRIMMED);
        add_beat(KIND_QUERY, '0);

        set_mode(MODE_PLAIN);
        queue_random(220, 30);

        set_mode(MODE_TRIMMED);
        queue_random(220, 30);

        set_mode(MODE_PLAIN);
        jitter_on = 1'b0;
        queue_random(220, 35);
        drain();
        jitter_on = 1'b1;

        set_mode(MODE_TRIMMED);
        queue_random(220, 30);

        set_mode(MODE_PLAIN);
        queue_random(220, 50);
        hold_go = 1'b1;

        set_mode(MODE_TRIMMED);
        queue_random(220, 25);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Accepted %0d input beats and checked %0d averages,", beats_in, means_checked);
        $display("covering both modes, an empty ring, wrap-round and a long output hold.");
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ trimmed_moving_average.f @@
rtl/tma_pkg.sv
rtl/tma_ram.sv
rtl/tma_div.sv
rtl/trimmed_moving_average.sv
bench/testbench.sv
